// ===== rtl/urxp_pkg.sv =====
`default_nettype none

package urxp_pkg;

  localparam int DATA_BITS  = 8;
  localparam int TICK_WIDTH = 16;
  localparam int CNT_W      = TICK_WIDTH + 1;
  localparam int BIT_IDX_W  = $clog2(DATA_BITS);
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [TICK_WIDTH-1:0] HALF_BIT_RESET = TICK_WIDTH'(1093);

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT_TICKS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_ODD     = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FRAMING = 2'd1,
    ST_PARITY  = 2'd2
  } frame_status_e;

  typedef struct packed {
    logic [TICK_WIDTH-1:0] half_bit_ticks;
    logic                  parity_odd;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/urxp_in_reg.sv =====
`default_nettype none

module urxp_in_reg (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic rx_level_i,
  input  logic take_i,
  output logic valid_o,
  output logic rx_o
);

  logic valid_q, valid_d;
  logic rx_q, rx_d;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    rx_d    = rx_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
      rx_d    = rx_level_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rx_q    <= 1'b1;
    end else begin
      valid_q <= valid_d;
      rx_q    <= rx_d;
    end
  end

  assign valid_o = valid_q;
  assign rx_o    = rx_q;

endmodule

`default_nettype wire

// ===== rtl/urxp_core.sv =====
`default_nettype none

module urxp_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  urxp_pkg::cfg_t               cfg_i,
  input  logic                         item_valid_i,
  input  logic                         item_rx_i,
  output logic                         take_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [urxp_pkg::BYTE_W-1:0]  received_byte_o,
  output logic [1:0]                   frame_status_o
);

  import urxp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_DATA,
    PH_PARITY,
    PH_STOP
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [CNT_W-1:0]       tick_q, tick_d;
  logic [BIT_IDX_W-1:0]   bit_q, bit_d;
  logic [DATA_BITS-1:0]   shift_q, shift_d;
  logic                   par_q, par_d;
  logic                   out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]      byte_q, byte_d;
  frame_status_e          status_q, status_d;

  logic [TICK_WIDTH-1:0]  half;
  logic [CNT_W-1:0]       target;
  logic [CNT_W-1:0]       tick_inc;
  logic                   due;
  logic                   expected;
  logic [DATA_BITS+BYTE_W-1:0] shift_ext;

  // advance only when the result register is free to take a result
  assign take_o = item_valid_i && (!out_valid_q || out_ready_i);

  // a half bit of zero behaves as one
  assign half      = (cfg_i.half_bit_ticks == '0) ? TICK_WIDTH'(1) : cfg_i.half_bit_ticks;
  assign target    = (phase_q == PH_START) ? {1'b0, half} : {half, 1'b0};
  assign tick_inc  = tick_q + CNT_W'(1);
  assign due       = (tick_inc >= target);
  assign expected  = (^shift_q) ^ cfg_i.parity_odd;
  assign shift_ext = {{BYTE_W{1'b0}}, shift_q};

  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    bit_d       = bit_q;
    shift_d     = shift_q;
    par_d       = par_q;
    out_valid_d = out_valid_q && !out_ready_i;
    byte_d      = byte_q;
    status_d    = status_q;
    if (take_o) begin
      case (phase_q)
        PH_IDLE: begin
          if (!item_rx_i) begin
            phase_d = PH_START;
            tick_d  = '0;
            bit_d   = '0;
            shift_d = '0;
            par_d   = 1'b0;
          end
        end
        PH_START: begin
          if (due) begin
            tick_d = '0;
            if (item_rx_i) begin
              phase_d     = PH_IDLE;
              out_valid_d = 1'b1;
              byte_d      = '0;
              status_d    = ST_FRAMING;
            end else begin
              phase_d = PH_DATA;
            end
          end else begin
            tick_d = tick_inc;
          end
        end
        PH_DATA: begin
          if (due) begin
            tick_d         = '0;
            shift_d[bit_q] = item_rx_i;
            if (bit_q == BIT_IDX_W'(DATA_BITS - 1)) begin
              bit_d   = '0;
              phase_d = PH_PARITY;
            end else begin
              bit_d = bit_q + BIT_IDX_W'(1);
            end
          end else begin
            tick_d = tick_inc;
          end
        end
        PH_PARITY: begin
          if (due) begin
            tick_d  = '0;
            par_d   = item_rx_i;
            phase_d = PH_STOP;
          end else begin
            tick_d = tick_inc;
          end
        end
        PH_STOP: begin
          // stop bit level is not checked
          if (due) begin
            tick_d      = '0;
            phase_d     = PH_IDLE;
            out_valid_d = 1'b1;
            byte_d      = shift_ext[BYTE_W-1:0];
            status_d    = (par_q != expected) ? ST_PARITY : ST_OK;
          end else begin
            tick_d = tick_inc;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          tick_d  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      par_q       <= 1'b0;
      out_valid_q <= 1'b0;
      byte_q      <= '0;
      status_q    <= ST_OK;
    end else begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      par_q       <= par_d;
      out_valid_q <= out_valid_d;
      byte_q      <= byte_d;
      status_q    <= status_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign received_byte_o = byte_q;
  assign frame_status_o  = status_q;

endmodule

`default_nettype wire

// ===== rtl/uart_receiver_with_parity.sv =====
// Timing: a line sample is registered in the input register on the edge it is transferred;
//   its result, if any, is registered in the result register when the core takes the sample.
// Throughput: one sample per cycle; the input register feeds the receive state machine
//   in a single pass, and a sample waits only while a finished result is not taken.
// Reset (rst_ni, async, active low): idle waiting for start, no result pending,
//   half_bit_ticks = 1093, parity_odd = 0 (even parity). No clearing pass.
`default_nettype none

module uart_receiver_with_parity (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [urxp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [urxp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             rx_level_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [7:0]                       received_byte_o,
  output logic [1:0]                       frame_status_o
);

  import urxp_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic [CFG_DATA_W+TICK_WIDTH-1:0] data_ext;
  logic item_valid;
  logic item_rx;
  logic take;

  assign cfg_ready_o = 1'b1;
  assign data_ext    = {{TICK_WIDTH{1'b0}}, cfg_data_i};

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_HALF_BIT_TICKS: cfg_d.half_bit_ticks = data_ext[TICK_WIDTH-1:0];
        CFG_PARITY_ODD:     cfg_d.parity_odd     = cfg_data_i[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_bit_ticks <= HALF_BIT_RESET;
      cfg_q.parity_odd     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  urxp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_level_i (rx_level_i),
    .take_i     (take),
    .valid_o    (item_valid),
    .rx_o       (item_rx)
  );

  urxp_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .item_valid_i    (item_valid),
    .item_rx_i       (item_rx),
    .take_o          (take),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .received_byte_o (received_byte_o),
    .frame_status_o  (frame_status_o)
  );

  // framing error never carries data
  a_framing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_status_o == ST_FRAMING) |-> received_byte_o == '0)
    else $error("framing error result with nonzero byte");

  // input side stalls only behind an untaken result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a pending result");

  a_cfg_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && cfg_index_i == CFG_PARITY_ODD)
      |=> cfg_q.parity_odd == $past(cfg_data_i[0]))
    else $error("parity sense write lost");

endmodule

`default_nettype wire
